@@ rtl/mfts_pkg.sv @@
// Shared types and constants for the multilevel feedback thread scheduler.
package mfts_pkg;

  localparam logic [13:0] QUANTUM_CAP = 14'd9999;

  localparam logic [1:0] CFG_INIT_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_SCHED_PERIOD = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd2;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CREATE = 1'b1;

  typedef struct packed {
    logic [13:0] quantum;
    logic [2:0]  prio;
    logic [7:0]  len;
    logic [7:0]  pc;
    logic [15:0] pid;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_VISIT,
    S_SEL,
    S_INST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic visit;
    logic sel;
    logic inst;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic s_end;
    logic take;
    logic out_free;
  } status_t;

endpackage

@@ rtl/mfts_ctrl.sv @@
// Controller state machine sequencing item intake, the scheduler pass and result output.
module mfts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  mfts_pkg::status_t status,
  output mfts_pkg::cmd_t    cmd
);

  mfts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfts_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mfts_pkg::S_CHK;
      end
      mfts_pkg::S_CHK: begin
        state_nxt = status.pass ? mfts_pkg::S_VISIT : mfts_pkg::S_DONE;
      end
      mfts_pkg::S_VISIT: begin
        state_nxt = status.s_end ? mfts_pkg::S_DONE : mfts_pkg::S_SEL;
      end
      mfts_pkg::S_SEL: begin
        state_nxt = status.take ? mfts_pkg::S_INST : mfts_pkg::S_VISIT;
      end
      mfts_pkg::S_INST: begin
        state_nxt = mfts_pkg::S_DONE;
      end
      mfts_pkg::S_DONE: begin
        if (status.out_free) state_nxt = mfts_pkg::S_IDLE;
      end
      default: state_nxt = mfts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == mfts_pkg::S_IDLE);
    cmd.accept = (state_r == mfts_pkg::S_IDLE) && in_tvalid;
    cmd.visit  = (state_r == mfts_pkg::S_VISIT);
    cmd.sel    = (state_r == mfts_pkg::S_SEL);
    cmd.inst   = (state_r == mfts_pkg::S_INST);
    cmd.fin    = (state_r == mfts_pkg::S_DONE) && status.out_free;
  end

endmodule

@@ rtl/mfts_dp.sv @@
// Datapath: slots, level queues with their memory, counters, config and result register.
module mfts_dp #(
  parameter int SLOTS       = 8,
  parameter int LEVELS      = 5,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mfts_pkg::cmd_t    cmd,
  output mfts_pkg::status_t status,
  input  logic              in_op,
  input  logic [7:0]        in_len,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(LEVELS);
  localparam int DW  = $clog2(LEVEL_DEPTH);
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int TW  = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam int AW  = LW + DW;

  // config
  logic [3:0] iq_r;
  logic [7:0] period_r;
  logic [3:0] act_r;

  // slots
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  mfts_pkg::rec_t    rec_r  [SLOTS];
  mfts_pkg::rec_t    rec_nxt[SLOTS];
  logic [13:0]       time_r  [SLOTS];
  logic [13:0]       time_nxt[SLOTS];

  // levels
  logic [DW-1:0] head_r[LEVELS], head_nxt[LEVELS];
  logic [DW-1:0] tail_r[LEVELS], tail_nxt[LEVELS];
  logic [CW-1:0] cnt_r [LEVELS], cnt_nxt [LEVELS];
  logic [TW-1:0] total_r, total_nxt;

  logic [15:0]    pid_r, pid_nxt;
  logic [7:0]     per_r, per_nxt;
  logic           pass_r, pass_nxt;
  logic [SCW-1:0] s_r, s_nxt;
  logic [SCW-1:0] fin_r, fin_nxt;
  logic           drop_r, drop_nxt;
  logic           dv_r, dv_nxt;
  logic [SW-1:0]  ds_r, ds_nxt;
  logic [15:0]    dpid_r, dpid_nxt;

  // level memory
  mfts_pkg::rec_t mem [1 << AW];
  mfts_pkg::rec_t rd_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  mfts_pkg::rec_t mem_wd;

  logic             enq_en;
  logic [LW-1:0]    enq_lvl;
  mfts_pkg::rec_t   enq_rec;

  logic [SCW-1:0]   n_use;
  logic [SW-1:0]    sidx;
  logic             s_end;
  logic             take;
  logic [LW-1:0]    hl;
  mfts_pkg::rec_t   vr;
  logic [27:0]      sq;
  logic [7:0]       pc1;
  logic [13:0]      t1;
  logic [3:0]       q0;

  logic             out_valid_r;
  logic [31:0]      out_data_r;

  assign n_use  = (int'(act_r) > SLOTS) ? SCW'(SLOTS) : SCW'(act_r);
  assign sidx   = s_r[SW-1:0];
  assign s_end  = (s_r >= n_use);
  assign take   = !busy_r[sidx] && (total_r != '0);
  assign vr     = rec_r[sidx];
  assign sq     = vr.quantum * vr.quantum + 28'd1;

  assign status.pass     = pass_r;
  assign status.s_end    = s_end;
  assign status.take     = take;
  assign status.out_free = !out_valid_r || out_tready;

  // highest non-empty level
  always_comb begin
    hl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[l] != '0) hl = LW'(l);
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    rec_nxt   = rec_r;
    time_nxt  = time_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    pid_nxt   = pid_r;
    per_nxt   = per_r;
    pass_nxt  = pass_r;
    s_nxt     = s_r;
    fin_nxt   = fin_r;
    drop_nxt  = drop_r;
    dv_nxt    = dv_r;
    ds_nxt    = ds_r;
    dpid_nxt  = dpid_r;
    enq_en    = 1'b0;
    enq_lvl   = '0;
    enq_rec   = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    pc1       = '0;
    t1        = '0;
    q0        = '0;

    if (cmd.accept) begin
      s_nxt    = '0;
      fin_nxt  = '0;
      drop_nxt = 1'b0;
      dv_nxt   = 1'b0;
      ds_nxt   = '0;
      dpid_nxt = '0;
      pass_nxt = 1'b0;
      if (in_op == mfts_pkg::OP_CREATE) begin
        q0              = (iq_r == '0) ? 4'd1 : iq_r;
        enq_en          = 1'b1;
        enq_lvl         = LW'(LEVELS - 1);
        enq_rec.pid     = pid_r;
        enq_rec.pc      = '0;
        enq_rec.len     = (in_len == '0) ? 8'd1 : in_len;
        enq_rec.prio    = 3'(LEVELS - 1);
        enq_rec.quantum = 14'(q0);
        pid_nxt         = pid_r + 16'd1;
        per_nxt         = '0;
        pass_nxt        = 1'b1;
      end else begin
        // advance every busy slot in use; pending slots hold and request a pass
        for (int i = 0; i < SLOTS; i++) begin
          if (busy_r[i] && (i < int'(n_use))) begin
            if ((rec_r[i].pc == rec_r[i].len) || (time_r[i] == rec_r[i].quantum)) begin
              pass_nxt = 1'b1;
            end else begin
              pc1            = rec_r[i].pc + 8'd1;
              t1             = time_r[i] + 14'd1;
              rec_nxt[i].pc  = pc1;
              time_nxt[i]    = t1;
              if ((pc1 == rec_r[i].len) || (t1 == rec_r[i].quantum)) pass_nxt = 1'b1;
            end
          end
        end
        if (per_r + 8'd1 == period_r) begin
          per_nxt  = '0;
          pass_nxt = 1'b1;
        end else begin
          per_nxt = per_r + 8'd1;
        end
      end
    end

    if (cmd.visit && !s_end && busy_r[sidx]) begin
      if (vr.pc == vr.len) begin
        busy_nxt[sidx] = 1'b0;
        time_nxt[sidx] = '0;
        fin_nxt        = fin_r + SCW'(1);
      end else if (time_r[sidx] == vr.quantum) begin
        if (total_r != '0) begin
          enq_en  = 1'b1;
          enq_rec = vr;
          if (vr.prio == '0) begin
            enq_rec.quantum = mfts_pkg::QUANTUM_CAP;
          end else begin
            enq_rec.quantum = (sq > 28'(mfts_pkg::QUANTUM_CAP)) ?
                              mfts_pkg::QUANTUM_CAP : sq[13:0];
            enq_rec.prio    = vr.prio - 3'd1;
          end
          enq_lvl        = enq_rec.prio[LW-1:0];
          busy_nxt[sidx] = 1'b0;
        end
        time_nxt[sidx] = '0;
      end
    end

    if (cmd.sel) begin
      if (take) begin
        mem_re       = 1'b1;
        mem_ra       = {hl, head_r[hl]};
        head_nxt[hl] = (head_r[hl] == DW'(LEVEL_DEPTH - 1)) ? '0 : head_r[hl] + DW'(1);
        cnt_nxt[hl]  = cnt_r[hl] - CW'(1);
        total_nxt    = total_r - TW'(1);
      end else begin
        s_nxt = s_r + SCW'(1);
      end
    end

    if (cmd.inst) begin
      rec_nxt[sidx]  = rd_r;
      busy_nxt[sidx] = 1'b1;
      time_nxt[sidx] = '0;
      dv_nxt         = 1'b1;
      ds_nxt         = sidx;
      dpid_nxt       = rd_r.pid;
    end

    // enqueue: drop when the level is full
    mem_we = 1'b0;
    mem_wa = {enq_lvl, tail_r[enq_lvl]};
    mem_wd = enq_rec;
    if (enq_en) begin
      if (cnt_r[enq_lvl] == CW'(LEVEL_DEPTH)) begin
        drop_nxt = 1'b1;
      end else begin
        mem_we            = 1'b1;
        tail_nxt[enq_lvl] = (tail_r[enq_lvl] == DW'(LEVEL_DEPTH - 1)) ? '0 :
                            tail_r[enq_lvl] + DW'(1);
        cnt_nxt[enq_lvl]  = cnt_r[enq_lvl] + CW'(1);
        total_nxt         = total_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    rec_r    <= rec_nxt;
    s_r      <= s_nxt;
    fin_r    <= fin_nxt;
    drop_r   <= drop_nxt;
    dv_r     <= dv_nxt;
    ds_r     <= ds_nxt;
    dpid_r   <= dpid_nxt;
    pass_r   <= pass_nxt;
    if (cmd.fin) begin
      out_data_r <= {drop_r, 7'(total_r), 4'(fin_r), dpid_r, 3'(ds_r), dv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r        <= 4'd2;
      period_r    <= 8'd25;
      act_r       <= 4'd8;
      busy_r      <= '0;
      time_r      <= '{default: '0};
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      total_r     <= '0;
      pid_r       <= 16'd1;
      per_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      time_r  <= time_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      pid_r   <= pid_nxt;
      per_r   <= per_nxt;
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          mfts_pkg::CFG_INIT_QUANTUM: iq_r     <= cfg_data[3:0];
          mfts_pkg::CFG_SCHED_PERIOD: period_r <= cfg_data[7:0];
          mfts_pkg::CFG_ACTIVE_SLOTS: act_r    <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/multilevel_feedback_thread_scheduler_unit.sv @@
// With no pass, an accepted item goes through the check and done states to the result.
// A pass visits the slots in turn (slot check, then queue select with the
// level-memory read) and ends by installing a dispatched item or by seeing the end
// of the walk; one item is in flight at a time.
// Throughput is bounded by the sequential slot walk over the shared queue memory.
// rst_n (synchronous) clears control state at once; no memory clearing pass.
module multilevel_feedback_thread_scheduler_unit #(
  parameter int SLOTS       = 8,
  parameter int LEVELS      = 5,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] process_length
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] dispatch_valid, [3:1] dispatch_slot, [19:4] dispatch_pid,
  // [23:20] finished_count, [30:24] waiting_count, [31] dropped
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mfts_pkg::cmd_t    cmd;
  mfts_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mfts_dp #(
    .SLOTS       (SLOTS),
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_op      (in_tuser),
    .in_len     (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after an accept");

  a_out_clear_on_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_fin_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> status.out_free)
    else $error("result loaded while previous one still held");

endmodule

@@ verif/multilevel_feedback_thread_scheduler_unit_tb.sv @@
// Self-checking testbench for the multilevel feedback thread scheduler unit.
module multilevel_feedback_thread_scheduler_unit_tb;

  localparam int NSLOT  = 8;
  localparam int NLEVEL = 5;
  localparam int DEPTH  = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        dropped;
    logic [6:0]  waiting;
    logic [3:0]  finished;
    logic [15:0] pid;
    logic [2:0]  slot;
    logic        dvalid;
  } sched_result_t;

  typedef struct {
    logic       op;
    logic [7:0] len;
    logic       known;
    logic [31:0] result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  multilevel_feedback_thread_scheduler_unit dut (.*);

  // scheduler image
  logic [3:0]      sh_quantum;
  logic [7:0]      sh_period;
  logic [3:0]      sh_active;
  logic            sh_busy [NSLOT];
  mfts_pkg::rec_t  sh_rec [NSLOT];
  logic [13:0]     sh_time [NSLOT];
  mfts_pkg::rec_t  sh_lvl [NLEVEL][DEPTH];
  int              sh_head [NLEVEL];
  int              sh_tail [NLEVEL];
  int              sh_cnt [NLEVEL];
  logic [15:0]     sh_next_pid;
  logic [7:0]      sh_pcount;

  sched_result_t expected_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;

  function automatic int waiting_total();
    int n = 0;
    for (int l = 0; l < NLEVEL; l++) n += sh_cnt[l];
    return n;
  endfunction

  function automatic bit level_push(int lvl, mfts_pkg::rec_t r);
    if (sh_cnt[lvl] >= DEPTH) return 0;
    sh_lvl[lvl][sh_tail[lvl]] = r;
    sh_tail[lvl] = (sh_tail[lvl] + 1) % DEPTH;
    sh_cnt[lvl]++;
    return 1;
  endfunction

  function automatic bit slot_pending(int s);
    return sh_rec[s].pc == sh_rec[s].len || sh_time[s] == sh_rec[s].quantum;
  endfunction

  task automatic sched_reset();
    sh_quantum = 2; sh_period = 25; sh_active = 8;
    for (int s = 0; s < NSLOT; s++) begin
      sh_busy[s] = 0; sh_rec[s] = '0; sh_time[s] = 0;
    end
    for (int l = 0; l < NLEVEL; l++) begin
      sh_head[l] = 0; sh_tail[l] = 0; sh_cnt[l] = 0;
    end
    sh_next_pid = 1; sh_pcount = 0;
  endtask

  function automatic sched_result_t schedule_item(logic op, logic [7:0] plen);
    sched_result_t res;
    int n;
    bit pass;
    mfts_pkg::rec_t r;
    logic [31:0] q, sq;
    logic [2:0] pr;
    res = '0;
    pass = 0;
    n = (sh_active > NSLOT) ? NSLOT : sh_active;
    if (op == mfts_pkg::OP_CREATE) begin
      r = '0;
      r.pid = sh_next_pid;
      r.len = (plen == 0) ? 8'd1 : plen;
      r.prio = 3'(NLEVEL - 1);
      r.quantum = (sh_quantum == 0) ? 14'd1 : 14'(sh_quantum);
      if (!level_push(NLEVEL - 1, r)) res.dropped = 1;
      sh_next_pid++;
      sh_pcount = 0;
      pass = 1;
    end else begin
      for (int s = 0; s < n; s++) begin
        if (!sh_busy[s]) continue;
        if (slot_pending(s)) begin
          pass = 1;
          continue;
        end
        sh_rec[s].pc++;
        sh_time[s]++;
        if (slot_pending(s)) pass = 1;
      end
      sh_pcount++;
      if (sh_pcount == sh_period) begin
        sh_pcount = 0;
        pass = 1;
      end
    end
    if (pass) begin
      for (int s = 0; s < n; s++) begin
        if (sh_busy[s]) begin
          r = sh_rec[s];
          if (r.pc == r.len) begin
            sh_busy[s] = 0; sh_time[s] = 0; res.finished++;
          end else if (sh_time[s] == r.quantum) begin
            if (waiting_total() > 0) begin
              pr = r.prio; q = r.quantum;
              if (pr == 0) q = mfts_pkg::QUANTUM_CAP;
              else begin
                sq = q * q + 1;
                q = (sq > mfts_pkg::QUANTUM_CAP) ? mfts_pkg::QUANTUM_CAP : sq;
                pr--;
              end
              r.prio = pr; r.quantum = q[13:0];
              if (!level_push(pr, r)) res.dropped = 1;
              sh_busy[s] = 0;
            end
            sh_time[s] = 0;
          end
        end
        if (!sh_busy[s]) begin
          bit got = 0;
          for (int l = NLEVEL - 1; l >= 0 && !got; l--) begin
            if (sh_cnt[l] > 0) begin
              sh_rec[s] = sh_lvl[l][sh_head[l]];
              sh_head[l] = (sh_head[l] + 1) % DEPTH;
              sh_cnt[l]--;
              got = 1;
            end
          end
          if (got) begin
            sh_busy[s] = 1; sh_time[s] = 0;
            res.dvalid = 1; res.slot = s[2:0]; res.pid = sh_rec[s].pid;
            break;
          end
        end
      end
    end
    res.waiting = 7'(waiting_total());
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mfts_pkg::CFG_INIT_QUANTUM: sh_quantum = val[3:0];
      mfts_pkg::CFG_SCHED_PERIOD: sh_period = val[7:0];
      mfts_pkg::CFG_ACTIVE_SLOTS: sh_active = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // hand one item over; expectation is queued at the accepting edge
  task automatic send_item(logic op, logic [7:0] plen, bit known, logic [31:0] typed);
    sched_result_t e;
    in_tvalid <= 1; in_tuser <= op; in_tdata <= plen;
    do @(posedge clk); while (!in_tready);
    e = schedule_item(op, plen);
    if (known && e != sched_result_t'(typed)) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, typed, e);
      errors++;
    end
    expected_results.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2 * NSLOT + 8) @(negedge clk);
  endtask

  task automatic burst(int count, int create_pct);
    int left;
    left = count;
    while (left > 0) begin
      int blen;
      int gap;
      blen = $urandom_range(1, 12);
      for (int i = 0; i < blen && left > 0; i++) begin
        if ($urandom_range(99) < create_pct)
          send_item(mfts_pkg::OP_CREATE, 8'($urandom_range(0, 255)), 0, '0);
        else
          send_item(mfts_pkg::OP_TICK, 8'($urandom), 0, '0);
        left--;
      end
      gap = ($urandom_range(3) != 0) ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 0;
  endtask

  stim_row_t dir_table[] = '{
    '{mfts_pkg::OP_CREATE, 8'd0,   1, {1'b0, 7'd0, 4'd0, 16'd1, 3'd0, 1'b1}},
    '{mfts_pkg::OP_TICK,   8'd255, 1, {1'b0, 7'd0, 4'd1, 16'd0, 3'd0, 1'b0}},
    '{mfts_pkg::OP_CREATE, 8'd255, 1, {1'b0, 7'd0, 4'd0, 16'd2, 3'd0, 1'b1}},
    '{mfts_pkg::OP_CREATE, 8'd1,   0, '0},
    '{mfts_pkg::OP_CREATE, 8'd128, 0, '0},
    '{mfts_pkg::OP_CREATE, 8'd3,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_CREATE, 8'd85,  0, '0},
    '{mfts_pkg::OP_CREATE, 8'd170, 0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0},
    '{mfts_pkg::OP_TICK,   8'd0,   0, '0}
  };

  // receiver: random stall pattern, plus one long hold-off
  initial begin
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else out_tready <= ($urandom_range(7) != 0) || ($urandom_range(1) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sched_result_t got;
      got = sched_result_t'(out_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
      end else begin
        sched_result_t e;
        e = expected_results.pop_front();
        if (got.dvalid !== e.dvalid)
          $display("%0t dispatch_valid: expected %0d actual %0d", $time, e.dvalid, got.dvalid);
        if (got.slot !== e.slot)
          $display("%0t dispatch_slot: expected %0d actual %0d", $time, e.slot, got.slot);
        if (got.pid !== e.pid)
          $display("%0t dispatch_pid: expected %0d actual %0d", $time, e.pid, got.pid);
        if (got.finished !== e.finished)
          $display("%0t finished_count: expected %0d actual %0d", $time, e.finished,
                   got.finished);
        if (got.waiting !== e.waiting)
          $display("%0t waiting_count: expected %0d actual %0d", $time, e.waiting,
                   got.waiting);
        if (got.dropped !== e.dropped)
          $display("%0t dropped: expected %0d actual %0d", $time, e.dropped, got.dropped);
        if (got !== e) errors++;
      end
    end
  end

  // watchdog on cycles with no accepted item of any kind
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || hold_off || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    sched_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (dir_table[i])
      send_item(dir_table[i].op, dir_table[i].len, dir_table[i].known, dir_table[i].result);
    in_tvalid <= 0;
    drain();
    // extremes: zero quantum and period, slots zero and above range
    cfg_write(mfts_pkg::CFG_INIT_QUANTUM, 16'hFFF0);
    cfg_write(mfts_pkg::CFG_SCHED_PERIOD, 16'd0);
    cfg_write(mfts_pkg::CFG_ACTIVE_SLOTS, 16'd0);
    burst(20, 60);
    drain();
    cfg_write(mfts_pkg::CFG_ACTIVE_SLOTS, 16'd15);
    cfg_write(mfts_pkg::CFG_INIT_QUANTUM, 16'd15);
    burst(40, 30);
    drain();
    cfg_write(mfts_pkg::CFG_INIT_QUANTUM, 16'd1);
    cfg_write(mfts_pkg::CFG_SCHED_PERIOD, 16'd1);
    cfg_write(mfts_pkg::CFG_ACTIVE_SLOTS, 16'd1);
    // fill levels to overflow with a single slot
    burst(60, 70);
    drain();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      burst(30, 50);
    join
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(mfts_pkg::CFG_INIT_QUANTUM, 16'($urandom_range(0, 15)));
      cfg_write(mfts_pkg::CFG_SCHED_PERIOD, 16'($urandom_range(0, 255)));
      cfg_write(mfts_pkg::CFG_ACTIVE_SLOTS, 16'($urandom_range(1, 8)));
      burst(50, $urandom_range(10, 50));
      drain();
    end
    cfg_write(mfts_pkg::CFG_INIT_QUANTUM, 16'd10);
    cfg_write(mfts_pkg::CFG_SCHED_PERIOD, 16'd255);
    cfg_write(mfts_pkg::CFG_ACTIVE_SLOTS, 16'd8);
    burst(60, 20);
    drain();
    if (errors == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
